// ===== hdl/tesp_pkg.sv =====
`default_nettype none

package tesp_pkg;

    typedef enum logic [3:0] {
        ST_GROUND    = 4'd0,
        ST_ESC       = 4'd1,
        ST_ESC_INT   = 4'd2,
        ST_CSI_ENTRY = 4'd3,
        ST_CSI_PARAM = 4'd4,
        ST_CSI_INT   = 4'd5,
        ST_CSI_IGN   = 4'd6,
        ST_OSC       = 4'd7,
        ST_DCS_ENTRY = 4'd8,
        ST_DCS_PARAM = 4'd9,
        ST_DCS_INT   = 4'd10,
        ST_DCS_PASS  = 4'd11,
        ST_DCS_IGN   = 4'd12,
        ST_SPA       = 4'd13
    } t_state;

    typedef enum logic [2:0] {
        ACT_IGNORE = 3'd0,
        ACT_EXEC   = 3'd1,
        ACT_PRINT  = 3'd2,
        ACT_ESC    = 3'd3,
        ACT_CSI    = 3'd4,
        ACT_OSC    = 3'd5,
        ACT_DCS    = 3'd6
    } t_action;

    localparam int unsigned CODE_W = 16;

    localparam logic [CODE_W-1:0] CH_BEL = 16'h0007;
    localparam logic [CODE_W-1:0] CH_CAN = 16'h0018;
    localparam logic [CODE_W-1:0] CH_SUB = 16'h001A;
    localparam logic [CODE_W-1:0] CH_ESC = 16'h001B;
    localparam logic [CODE_W-1:0] CH_DEL = 16'h007F;
    localparam logic [CODE_W-1:0] CH_DCS = 16'h0090;
    localparam logic [CODE_W-1:0] CH_SOS = 16'h0098;
    localparam logic [CODE_W-1:0] CH_CSI = 16'h009B;
    localparam logic [CODE_W-1:0] CH_ST  = 16'h009C;
    localparam logic [CODE_W-1:0] CH_OSC = 16'h009D;
    localparam logic [CODE_W-1:0] CH_PM  = 16'h009E;
    localparam logic [CODE_W-1:0] CH_APC = 16'h009F;

    localparam logic [CODE_W-1:0] CH_COLON  = 16'h003A;
    localparam logic [CODE_W-1:0] CH_SEMI   = 16'h003B;
    localparam logic [CODE_W-1:0] CH_ESC_P  = 16'h0050;
    localparam logic [CODE_W-1:0] CH_ESC_X  = 16'h0058;
    localparam logic [CODE_W-1:0] CH_ESC_LB = 16'h005B;
    localparam logic [CODE_W-1:0] CH_ESC_RB = 16'h005D;
    localparam logic [CODE_W-1:0] CH_ESC_CA = 16'h005E;
    localparam logic [CODE_W-1:0] CH_ESC_US = 16'h005F;

endpackage

`default_nettype wire

// ===== hdl/terminal_escape_sequence_parser.sv =====
// Pipeline: the character is captured in the input register, then decoded into the result
// register (o_valid); decoding stalls while the result register is full and i_ready is low.
// Throughput: one character per cycle while i_ready is high (one pass of decode logic).
// Reset (synchronous, i_rst_n low): parser returns to ground, both stages empty.
`default_nettype none

module terminal_escape_sequence_parser
    import tesp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [CODE_W-1:0] i_code_point,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [2:0]             o_action,
    output logic                   o_append_char,
    output logic                   o_intermediate_begin
);

    logic              r_in_valid;
    logic [CODE_W-1:0] r_code;
    t_state            r_state;
    t_state            n_state;
    t_action           n_action;
    logic              n_app;
    logic              n_ib;
    logic              r_out_valid;
    t_action           r_action;
    logic              r_app;
    logic              r_ib;
    logic              advance;

    function automatic logic in_rng(input logic [CODE_W-1:0] c,
                                    input logic [CODE_W-1:0] lo,
                                    input logic [CODE_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    logic c_ctl;
    logic c_st;
    logic c_exec_any;
    logic c_to_esc;
    logic c_to_dcs;
    logic c_to_spa;
    logic c_to_csi;
    logic c_to_osc;
    logic c_int;
    logic c_digit;
    logic c_param_ign;

    // Advance the decode stage when it holds a character and the result register is free or draining
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_comb begin
        c_ctl       = in_rng(r_code, 16'h0000, 16'h0017) || (r_code == 16'h0019) ||
                      in_rng(r_code, 16'h001C, 16'h001F);
        c_st        = (r_code == CH_ST);
        c_exec_any  = (r_code == CH_CAN) || (r_code == CH_SUB) ||
                      in_rng(r_code, 16'h0080, 16'h008F) ||
                      in_rng(r_code, 16'h0091, 16'h0097) ||
                      (r_code == 16'h0099) || (r_code == 16'h009A);
        c_to_esc    = (r_code == CH_ESC);
        c_to_dcs    = (r_code == CH_DCS);
        c_to_spa    = (r_code == CH_SOS) || (r_code == CH_PM) || (r_code == CH_APC);
        c_to_csi    = (r_code == CH_CSI);
        c_to_osc    = (r_code == CH_OSC);
        c_int       = in_rng(r_code, 16'h0020, 16'h002F);
        c_digit     = in_rng(r_code, 16'h0030, 16'h0039) || (r_code == CH_SEMI);
        c_param_ign = (r_code == CH_COLON) || in_rng(r_code, 16'h003C, 16'h003F);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        if (c_st || c_exec_any) begin
            n_state = ST_GROUND;
        end else if (c_to_esc) begin
            n_state = ST_ESC;
        end else if (c_to_dcs) begin
            n_state = ST_DCS_ENTRY;
        end else if (c_to_spa) begin
            n_state = ST_SPA;
        end else if (c_to_csi) begin
            n_state = ST_CSI_ENTRY;
        end else if (c_to_osc) begin
            n_state = ST_OSC;
        end else begin
            unique case (r_state)
                ST_ESC: begin
                    if (c_ctl || r_code == CH_DEL) n_state = ST_ESC;
                    else if (c_int) n_state = ST_ESC_INT;
                    else if (r_code == CH_ESC_P) n_state = ST_DCS_ENTRY;
                    else if (r_code == CH_ESC_X || r_code == CH_ESC_CA ||
                             r_code == CH_ESC_US) n_state = ST_SPA;
                    else if (r_code == CH_ESC_LB) n_state = ST_CSI_ENTRY;
                    else if (r_code == CH_ESC_RB) n_state = ST_OSC;
                    else n_state = ST_GROUND;
                end
                ST_ESC_INT: begin
                    if (!(c_ctl || r_code == CH_DEL || c_int)) n_state = ST_GROUND;
                end
                ST_CSI_ENTRY: begin
                    if (c_ctl || r_code == CH_DEL) n_state = ST_CSI_ENTRY;
                    else if (c_int) n_state = ST_CSI_INT;
                    else if (r_code == CH_COLON) n_state = ST_CSI_IGN;
                    else if (in_rng(r_code, 16'h0040, 16'h007E)) n_state = ST_GROUND;
                    else n_state = ST_CSI_PARAM;
                end
                ST_CSI_PARAM: begin
                    if (c_ctl || r_code == CH_DEL || c_digit) n_state = ST_CSI_PARAM;
                    else if (c_int) n_state = ST_CSI_INT;
                    else if (c_param_ign) n_state = ST_CSI_IGN;
                    else n_state = ST_GROUND;
                end
                ST_CSI_INT: begin
                    if (c_ctl || r_code == CH_DEL || c_int) n_state = ST_CSI_INT;
                    else if (in_rng(r_code, 16'h0030, 16'h003F)) n_state = ST_CSI_IGN;
                    else n_state = ST_GROUND;
                end
                ST_CSI_IGN: begin
                    if (!c_ctl && in_rng(r_code, 16'h0040, 16'h007E)) n_state = ST_GROUND;
                end
                ST_OSC: begin
                    if (r_code == CH_BEL) n_state = ST_GROUND;
                end
                ST_DCS_ENTRY: begin
                    if (c_ctl || r_code == CH_DEL) n_state = ST_DCS_ENTRY;
                    else if (c_int) n_state = ST_DCS_INT;
                    else if (r_code == CH_COLON) n_state = ST_DCS_IGN;
                    else if (in_rng(r_code, 16'h0030, 16'h003F)) n_state = ST_DCS_PARAM;
                    else n_state = ST_DCS_PASS;
                end
                ST_DCS_PARAM: begin
                    if (c_ctl || r_code == CH_DEL || c_digit) n_state = ST_DCS_PARAM;
                    else if (c_int) n_state = ST_DCS_INT;
                    else if (c_param_ign) n_state = ST_DCS_IGN;
                    else n_state = ST_DCS_PASS;
                end
                ST_DCS_INT: begin
                    if (c_ctl || r_code == CH_DEL || c_int) n_state = ST_DCS_INT;
                    else if (in_rng(r_code, 16'h0030, 16'h003F)) n_state = ST_DCS_IGN;
                    else n_state = ST_DCS_PASS;
                end
                ST_DCS_PASS, ST_DCS_IGN, ST_SPA: begin
                    n_state = r_state;
                end
                default: begin
                    n_state = ST_GROUND;
                end
            endcase
        end
    end

    // Outputs
    always_comb begin
        n_action = ACT_IGNORE;
        n_app    = 1'b0;
        n_ib     = 1'b0;
        if (c_st) begin
            if (r_state == ST_OSC) n_action = ACT_OSC;
            else if (r_state == ST_DCS_PASS) n_action = ACT_DCS;
        end else if (c_exec_any) begin
            n_action = ACT_EXEC;
        end else if (c_to_esc || c_to_dcs || c_to_spa || c_to_csi || c_to_osc) begin
            n_action = ACT_IGNORE;
        end else begin
            unique case (r_state)
                ST_ESC: begin
                    if (c_ctl) n_action = ACT_EXEC;
                    else if (c_int) begin
                        n_app = 1'b1;
                        n_ib  = 1'b1;
                    end else if (r_code == CH_DEL || r_code == CH_ESC_P ||
                                 r_code == CH_ESC_X || r_code == CH_ESC_CA ||
                                 r_code == CH_ESC_US || r_code == CH_ESC_LB ||
                                 r_code == CH_ESC_RB) begin
                        n_action = ACT_IGNORE;
                    end else begin
                        n_action = ACT_ESC;
                        n_app    = 1'b1;
                    end
                end
                ST_ESC_INT: begin
                    if (c_ctl) n_action = ACT_EXEC;
                    else if (r_code == CH_DEL) n_action = ACT_IGNORE;
                    else if (c_int) n_app = 1'b1;
                    else begin
                        n_action = ACT_ESC;
                        n_app    = 1'b1;
                    end
                end
                ST_CSI_ENTRY: begin
                    if (c_ctl) n_action = ACT_EXEC;
                    else if (r_code == CH_DEL || r_code == CH_COLON) n_action = ACT_IGNORE;
                    else if (c_int) begin
                        n_app = 1'b1;
                        n_ib  = 1'b1;
                    end else if (in_rng(r_code, 16'h0040, 16'h007E)) begin
                        n_action = ACT_CSI;
                        n_app    = 1'b1;
                    end else n_app = 1'b1;
                end
                ST_CSI_PARAM: begin
                    if (c_ctl) n_action = ACT_EXEC;
                    else if (r_code == CH_DEL || c_param_ign) n_action = ACT_IGNORE;
                    else if (c_digit) n_app = 1'b1;
                    else if (c_int) begin
                        n_app = 1'b1;
                        n_ib  = 1'b1;
                    end else begin
                        n_action = ACT_CSI;
                        n_app    = 1'b1;
                    end
                end
                ST_CSI_INT: begin
                    if (c_ctl) n_action = ACT_EXEC;
                    else if (r_code == CH_DEL) n_action = ACT_IGNORE;
                    else if (c_int) n_app = 1'b1;
                    else if (in_rng(r_code, 16'h0030, 16'h003F)) n_action = ACT_IGNORE;
                    else begin
                        n_action = ACT_CSI;
                        n_app    = 1'b1;
                    end
                end
                ST_CSI_IGN: begin
                    if (c_ctl) n_action = ACT_EXEC;
                end
                ST_OSC: begin
                    if (r_code == CH_BEL) n_action = ACT_OSC;
                    else if (!c_ctl) n_app = 1'b1;
                end
                ST_DCS_ENTRY: begin
                    if (c_ctl || r_code == CH_DEL || r_code == CH_COLON) n_app = 1'b0;
                    else if (c_int) begin
                        n_app = 1'b1;
                        n_ib  = 1'b1;
                    end else n_app = 1'b1;
                end
                ST_DCS_PARAM: begin
                    if (c_ctl || r_code == CH_DEL || c_param_ign) n_app = 1'b0;
                    else if (c_int) begin
                        n_app = 1'b1;
                        n_ib  = 1'b1;
                    end else n_app = 1'b1;
                end
                ST_DCS_INT: begin
                    if (c_ctl || r_code == CH_DEL) n_app = 1'b0;
                    else if (in_rng(r_code, 16'h0030, 16'h003F)) n_app = 1'b0;
                    else n_app = 1'b1;
                end
                ST_DCS_PASS: begin
                    n_app = (r_code != CH_DEL);
                end
                ST_DCS_IGN, ST_SPA: begin
                    n_action = ACT_IGNORE;
                end
                default: begin
                    n_action = c_ctl ? ACT_EXEC : ACT_PRINT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_GROUND;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_code <= i_code_point;
        end
        if (advance) begin
            r_action <= n_action;
            r_app    <= n_app;
            r_ib     <= n_ib;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_action             = r_action;
    assign o_append_char        = r_app;
    assign o_intermediate_begin = r_ib;

`ifndef NO_ASSERTIONS
    a_reset_ground: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == ST_GROUND) && !o_valid)
        else $error("parser not in ground after reset");

    a_ib_implies_app: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_ib |-> n_app)
        else $error("intermediate begin without append");

    a_esc_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_code == CH_ESC) |=> (r_state == ST_ESC))
        else $error("escape did not enter escape state");

    a_print_ground: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (n_action == ACT_PRINT) |=> (r_state == ST_GROUND))
        else $error("print left parser outside ground");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("parser state moved without a transfer");
`endif

endmodule

`default_nettype wire
